### rtl/lrq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrq_pkg;

    // Fixed field widths of a request and of a result.
    localparam int REQ_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;

    // Default size of the slot pool.
    localparam int SLOTS_DEFAULT = 64;

    // Request kinds.
    localparam logic [REQ_W-1:0] OP_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] OP_POP    = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

    // One result as it travels from the sequencer to the output register.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   popped_id;
        logic                queue_empty;
    } result_t;

endpackage

`default_nettype wire

### rtl/lrq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port memory: one write port, one read port with registered data.
module lrq_ram #(
    parameter int DEPTH = lrq_pkg::SLOTS_DEFAULT,
    parameter int WIDTH = lrq_pkg::SLOT_W
) (
    input  wire logic                     clk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/lrq_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Request sequencer: holds head, tail and the non-empty flag, and drives the
// link and membership memories through read, modify and write-back steps.
module lrq_seq #(
    parameter int SLOTS = lrq_pkg::SLOTS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [lrq_pkg::REQ_W-1:0]      req_type,
    input  wire logic [lrq_pkg::SLOT_W-1:0]     slot_id,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output lrq_pkg::result_t                    res,
    output logic                                link_rd_en,
    output logic      [$clog2(SLOTS)-1:0]       link_rd_addr,
    input  wire logic [$clog2(SLOTS)-1:0]       link_rd_data,
    output logic                                link_wr_en,
    output logic      [$clog2(SLOTS)-1:0]       link_wr_addr,
    output logic      [$clog2(SLOTS)-1:0]       link_wr_data,
    output logic                                flag_rd_en,
    output logic      [$clog2(SLOTS)-1:0]       flag_rd_addr,
    input  wire logic [0:0]                     flag_rd_data,
    output logic                                flag_wr_en,
    output logic      [$clog2(SLOTS)-1:0]       flag_wr_addr,
    output logic      [0:0]                     flag_wr_data
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int STEP_W = $clog2(SLOTS + 1);
    localparam int SW     = lrq_pkg::SLOT_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_SPLICE = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;

    logic [2:0]                    state_reg,   state_next;
    logic [IDX_W-1:0]              head_reg,    head_next;
    logic [IDX_W-1:0]              tail_reg,    tail_next;
    logic                          has_reg,     has_next;
    logic [IDX_W-1:0]              clr_reg,     clr_next;
    logic [IDX_W-1:0]              cur_reg,     cur_next;
    logic [STEP_W-1:0]             steps_reg,   steps_next;
    logic [lrq_pkg::REQ_W-1:0]     op_reg,      op_next;
    logic [SW-1:0]                 slot_reg,    slot_next;
    logic [lrq_pkg::STATUS_W-1:0]  status_reg,  status_next;
    logic [SW-1:0]                 popped_reg,  popped_next;

    logic             in_ok;
    logic             s_ok;
    logic [IDX_W-1:0] s_idx;
    logic             nx_ok;

    assign in_ok = (32'(slot_id) < SLOTS);
    assign s_ok  = (32'(slot_reg) < SLOTS);
    assign s_idx = IDX_W'(slot_reg);
    assign nx_ok = (32'(link_rd_data) < SLOTS);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);

    always_comb
    begin
        res.status      = status_reg;
        res.popped_id   = popped_reg;
        res.queue_empty = ~has_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        has_next     = has_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        steps_next   = steps_reg;
        op_next      = op_reg;
        slot_next    = slot_reg;
        status_next  = status_reg;
        popped_next  = popped_reg;

        link_rd_en   = 1'b0;
        link_rd_addr = head_reg;
        link_wr_en   = 1'b0;
        link_wr_addr = tail_reg;
        link_wr_data = s_idx;
        flag_rd_en   = 1'b0;
        flag_rd_addr = IDX_W'(slot_id);
        flag_wr_en   = 1'b0;
        flag_wr_addr = s_idx;
        flag_wr_data = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                flag_wr_en   = 1'b1;
                flag_wr_addr = clr_reg;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = req_type;
                    slot_next   = slot_id;
                    popped_next = '0;
                    status_next = lrq_pkg::STAT_OK;
                    flag_rd_en  = in_ok;
                    link_rd_en  = 1'b1;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_RESP;
                case (op_reg)
                    lrq_pkg::OP_APPEND:
                    begin
                        if (!s_ok || flag_rd_data[0])
                        begin
                            status_next = lrq_pkg::STAT_DUP;
                        end
                        else
                        begin
                            flag_wr_en   = 1'b1;
                            flag_wr_data = 1'b1;
                            tail_next    = s_idx;
                            if (has_reg)
                            begin
                                link_wr_en = 1'b1;
                            end
                            else
                            begin
                                head_next = s_idx;
                                has_next  = 1'b1;
                            end
                        end
                    end

                    lrq_pkg::OP_REMOVE:
                    begin
                        if (!s_ok || !flag_rd_data[0] || !has_reg)
                        begin
                            status_next = lrq_pkg::STAT_NOTFOUND;
                        end
                        else if (s_idx == head_reg)
                        begin
                            flag_wr_en   = 1'b1;
                            flag_wr_addr = head_reg;
                            if (head_reg == tail_reg)
                            begin
                                has_next  = 1'b0;
                                head_next = '0;
                                tail_next = '0;
                            end
                            else
                            begin
                                head_next = link_rd_data;
                            end
                        end
                        else if (head_reg == tail_reg)
                        begin
                            status_next = lrq_pkg::STAT_NOTFOUND;
                        end
                        else
                        begin
                            // The link of the head is already in the read register.
                            cur_next   = head_reg;
                            steps_next = '0;
                            state_next = S_WALK;
                        end
                    end

                    lrq_pkg::OP_POP:
                    begin
                        if (has_reg)
                        begin
                            popped_next  = SW'(head_reg);
                            flag_wr_en   = 1'b1;
                            flag_wr_addr = head_reg;
                            if (head_reg == tail_reg)
                            begin
                                has_next  = 1'b0;
                                head_next = '0;
                                tail_next = '0;
                            end
                            else
                            begin
                                head_next = link_rd_data;
                            end
                        end
                        else
                        begin
                            status_next = lrq_pkg::STAT_EMPTY;
                        end
                    end

                    default:
                    begin
                        status_next = lrq_pkg::STAT_OK;
                    end
                endcase
            end

            S_WALK:
            begin
                // The read register holds the successor of cur_reg.
                if (!nx_ok)
                begin
                    status_next = lrq_pkg::STAT_NOTFOUND;
                    state_next  = S_RESP;
                end
                else if (link_rd_data == s_idx)
                begin
                    if (s_idx == tail_reg)
                    begin
                        tail_next  = cur_reg;
                        flag_wr_en = 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        link_rd_en   = 1'b1;
                        link_rd_addr = s_idx;
                        state_next   = S_SPLICE;
                    end
                end
                else
                begin
                    cur_next   = link_rd_data;
                    steps_next = steps_reg + 1'b1;
                    if ((32'(steps_reg) + 32'd1 < SLOTS) && (link_rd_data != tail_reg))
                    begin
                        link_rd_en   = 1'b1;
                        link_rd_addr = link_rd_data;
                    end
                    else
                    begin
                        status_next = lrq_pkg::STAT_NOTFOUND;
                        state_next  = S_RESP;
                    end
                end
            end

            S_SPLICE:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = cur_reg;
                link_wr_data = link_rd_data;
                flag_wr_en   = 1'b1;
                state_next   = S_RESP;
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            head_reg  <= '0;
            tail_reg  <= '0;
            has_reg   <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            has_reg   <= has_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        steps_reg  <= steps_next;
        op_reg     <= op_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        popped_reg <= popped_next;
    end

endmodule

`default_nettype wire

### rtl/linked_request_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  tdata                                   tuser
// s_*      in   [5:0] slot_id, [7:6] zero               [1:0] req_type
// m_*      out  [5:0] popped_id, [6] queue_empty, [7] 0 [1:0] status
//
// A simple request (append, pop, head removal, unused kind) passes through
// the EXEC and RESP states to the output register; the next request is
// taken once the sequencer is back in IDLE. Removing a slot behind the head
// walks the links from the head in WALK, plus SPLICE if it is not the tail.
// After reset the membership memory is swept clear with the input closed.
// Only a second finished result stalls behind one in the output register.
module linked_request_queue #(
    parameter int SLOTS = lrq_pkg::SLOTS_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [5:0] slot_id, [7:6] zero
    input  wire logic [1:0] s_tuser,   // [1:0] req_type
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [5:0] popped_id, [6] queue_empty, [7] zero
    output logic      [1:0] m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(SLOTS);

    // Sequencer to result register.
    logic             res_valid;
    logic             res_ready;
    lrq_pkg::result_t res;

    // Link memory ports.
    logic             link_rd_en;
    logic [IDX_W-1:0] link_rd_addr;
    logic [IDX_W-1:0] link_rd_data;
    logic             link_wr_en;
    logic [IDX_W-1:0] link_wr_addr;
    logic [IDX_W-1:0] link_wr_data;

    // Membership memory ports.
    logic             flag_rd_en;
    logic [IDX_W-1:0] flag_rd_addr;
    logic [0:0]       flag_rd_data;
    logic             flag_wr_en;
    logic [IDX_W-1:0] flag_wr_addr;
    logic [0:0]       flag_wr_data;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    lrq_pkg::result_t out_res_reg,   out_res_next;

    lrq_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .req_type     (s_tuser),
        .slot_id      (s_tdata[5:0]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .link_rd_en   (link_rd_en),
        .link_rd_addr (link_rd_addr),
        .link_rd_data (link_rd_data),
        .link_wr_en   (link_wr_en),
        .link_wr_addr (link_wr_addr),
        .link_wr_data (link_wr_data),
        .flag_rd_en   (flag_rd_en),
        .flag_rd_addr (flag_rd_addr),
        .flag_rd_data (flag_rd_data),
        .flag_wr_en   (flag_wr_en),
        .flag_wr_addr (flag_wr_addr),
        .flag_wr_data (flag_wr_data)
    );

    // Successor of each queued slot; unwritten entries may be read, but their data is not used.
    lrq_ram #(
        .DEPTH (SLOTS),
        .WIDTH (IDX_W)
    ) u_link_ram (
        .clk     (clk),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data)
    );

    // One membership bit per slot, cleared by the sweep after reset.
    lrq_ram #(
        .DEPTH (SLOTS),
        .WIDTH (1)
    ) u_flag_ram (
        .clk     (clk),
        .rd_en   (flag_rd_en),
        .rd_addr (flag_rd_addr),
        .rd_data (flag_rd_data),
        .wr_en   (flag_wr_en),
        .wr_addr (flag_wr_addr),
        .wr_data (flag_wr_data)
    );

    // The result register takes a new result whenever it is empty or being
    // emptied in the same cycle.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.queue_empty, out_res_reg.popped_id};
    assign m_tuser  = out_res_reg.status;

    // A request is never taken while the sequencer still holds a result.
    a_no_accept_while_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid |-> !s_tready
    ) else $error("request accepted while a result is pending");

    // Only one request is in flight: acceptance closes the input at once.
    a_one_in_flight: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready
    ) else $error("input stayed open after a request was accepted");

    // A slot number is only reported with a successful pop.
    a_popped_only_ok: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != lrq_pkg::STAT_OK)) |-> (m_tdata[5:0] == 6'd0)
    ) else $error("slot number reported with a failing status");

    // A pop that found nothing must also report an empty queue.
    a_empty_consistent: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == lrq_pkg::STAT_EMPTY)) |-> m_tdata[6]
    ) else $error("empty status with a non-empty queue");

endmodule

`default_nettype wire
